### sv/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

  localparam logic [31:0] LIMIT_SECONDS = 32'd4102444800;

  // days = (secs >> 7) / 675, reciprocal scaled by 2^32
  localparam logic [22:0] DAY_RECIP  = 23'd6362914;
  localparam logic [9:0]  DAY_DIV    = 10'd675;

  // four-year cycle, reciprocal scaled by 2^27
  localparam logic [16:0] CYC_RECIP  = 17'd91867;
  localparam logic [10:0] CYC_DAYS   = 11'd1461;

  // hour, reciprocal scaled by 2^28
  localparam logic [16:0] HOUR_RECIP = 17'd74565;
  localparam logic [11:0] HOUR_SECS  = 12'd3600;

  // minute, reciprocal scaled by 2^16
  localparam logic [10:0] MIN_RECIP  = 11'd1092;
  localparam logic [5:0]  MIN_SECS   = 6'd60;

  localparam logic [11:0] FIRST_YEAR = 12'd1970;
  localparam logic [11:0] FIRST_LEAP = 12'd1972;
  localparam logic [15:0] YEAR_DAYS  = 16'd365;

  typedef enum logic [2:0] {
    YR_1970  = 3'b001,
    YR_1971  = 3'b010,
    YR_CYCLE = 3'b100
  } yr_cls_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  // first day of year for a zero-based month
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    begin
      case (m)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && (m >= 4'd2)) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

### sv/esc_daysplit.sv
`timescale 1ns / 1ps
module esc_daysplit
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] secs,
  output logic [15:0] days,
  output logic [16:0] rem
);

  logic [47:0] prod_r, prod_nxt;
  logic [24:0] s7_r;
  logic [6:0]  lo7_r;
  logic [15:0] days_r, days_nxt;
  logic [16:0] rem_r, rem_nxt;

  logic [15:0] q0;
  logic [25:0] r_full;
  logic [10:0] r0;
  logic [9:0]  r;

  assign prod_nxt = 48'(secs[31:7]) * 48'(DAY_RECIP);

  always_comb begin
    q0     = prod_r[47:32];
    r_full = 26'(s7_r) - 26'(q0) * 26'(DAY_DIV);
    r0     = r_full[10:0];
    if (r0 >= 11'(DAY_DIV)) begin
      days_nxt = q0 + 16'd1;
      r        = 10'(r0 - 11'(DAY_DIV));
    end else begin
      days_nxt = q0;
      r        = r0[9:0];
    end
    rem_nxt = {r, lo7_r};
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    s7_r   <= secs[31:7];
    lo7_r  <= secs[6:0];
    days_r <= days_nxt;
    rem_r  <= rem_nxt;
  end

  assign days = days_r;
  assign rem  = rem_r;

endmodule

### sv/esc_date.sv
`timescale 1ns / 1ps
module esc_date
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] days,
  output date_t       date
);

  // stage 3: year class and cycle product
  yr_cls_t     cls3_r, cls3_nxt;
  logic [15:0] e3_r, e3_nxt;
  logic [32:0] p3_r, p3_nxt;

  // stage 4: cycle number and day in cycle
  yr_cls_t     cls4_r;
  logic [5:0]  cyc4_r, cyc4_nxt;
  logic [10:0] c4_r, c4_nxt;

  // stage 5: year and day of year
  logic [11:0] year5_r, year5_nxt;
  logic [8:0]  doy5_r, doy5_nxt;
  logic        leap5_r, leap5_nxt;

  date_t       date_r, date_nxt;

  logic [5:0]  cyc0;
  logic [16:0] c_full;
  logic [11:0] c0;
  logic [1:0]  off;
  logic [3:0]  m;

  always_comb begin
    if (days < YEAR_DAYS) begin
      cls3_nxt = YR_1970;
      e3_nxt   = days;
    end else if (days < (YEAR_DAYS << 1)) begin
      cls3_nxt = YR_1971;
      e3_nxt   = days - YEAR_DAYS;
    end else begin
      cls3_nxt = YR_CYCLE;
      e3_nxt   = days - (YEAR_DAYS << 1);
    end
    p3_nxt = 33'(e3_nxt) * 33'(CYC_RECIP);
  end

  always_comb begin
    cyc0   = p3_r[32:27];
    c_full = 17'(e3_r) - 17'(cyc0) * 17'(CYC_DAYS);
    c0     = c_full[11:0];
    if (cls3_r != YR_CYCLE) begin
      cyc4_nxt = '0;
      c4_nxt   = e3_r[10:0];
    end else if (c0 >= 12'(CYC_DAYS)) begin
      cyc4_nxt = cyc0 + 6'd1;
      c4_nxt   = 11'(c0 - 12'(CYC_DAYS));
    end else begin
      cyc4_nxt = cyc0;
      c4_nxt   = c0[10:0];
    end
  end

  always_comb begin
    off       = 2'd0;
    leap5_nxt = 1'b0;
    doy5_nxt  = c4_r[8:0];
    year5_nxt = FIRST_YEAR;
    case (cls4_r)
      YR_1970: begin
        year5_nxt = FIRST_YEAR;
      end
      YR_1971: begin
        year5_nxt = FIRST_YEAR + 12'd1;
      end
      YR_CYCLE: begin
        if (c4_r < 11'd366) begin
          off       = 2'd0;
          leap5_nxt = 1'b1;
          doy5_nxt  = c4_r[8:0];
        end else if (c4_r < 11'd731) begin
          off      = 2'd1;
          doy5_nxt = 9'(c4_r - 11'd366);
        end else if (c4_r < 11'd1096) begin
          off      = 2'd2;
          doy5_nxt = 9'(c4_r - 11'd731);
        end else begin
          off      = 2'd3;
          doy5_nxt = 9'(c4_r - 11'd1096);
        end
        year5_nxt = FIRST_LEAP + {4'd0, cyc4_r, 2'b00} + {10'd0, off};
      end
      default: begin
        year5_nxt = FIRST_YEAR;
      end
    endcase
  end

  always_comb begin
    m = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy5_r >= month_start(4'(i), leap5_r)) begin
        m = 4'(i);
      end
    end
    date_nxt.year  = year5_r;
    date_nxt.month = m + 4'd1;
    date_nxt.day   = 5'(doy5_r - month_start(m, leap5_r) + 9'd1);
  end

  always_ff @(posedge clk) begin
    cls3_r  <= cls3_nxt;
    e3_r    <= e3_nxt;
    p3_r    <= p3_nxt;
    cls4_r  <= cls3_r;
    cyc4_r  <= cyc4_nxt;
    c4_r    <= c4_nxt;
    year5_r <= year5_nxt;
    doy5_r  <= doy5_nxt;
    leap5_r <= leap5_nxt;
    date_r  <= date_nxt;
  end

  assign date = date_r;

endmodule

### sv/esc_tod.sv
`timescale 1ns / 1ps
module esc_tod
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic [16:0] rem,
  output tod_t        tod
);

  logic [33:0] ph3_r, ph3_nxt;
  logic [16:0] rem3_r;
  logic [4:0]  hour4_r, hour4_nxt;
  logic [11:0] rh4_r, rh4_nxt;
  logic [4:0]  hour5_r;
  logic [22:0] pm5_r, pm5_nxt;
  logic [11:0] rh5_r;
  tod_t        tod_r, tod_nxt;

  logic [4:0]  h0;
  logic [16:0] rh_full;
  logic [12:0] rh0;
  logic [5:0]  m0;
  logic [11:0] s_full;
  logic [6:0]  s0;

  assign ph3_nxt = 34'(rem) * 34'(HOUR_RECIP);
  assign pm5_nxt = 23'(rh4_r) * 23'(MIN_RECIP);

  always_comb begin
    h0      = ph3_r[32:28];
    rh_full = rem3_r - 17'(h0) * 17'(HOUR_SECS);
    rh0     = rh_full[12:0];
    if (rh0 >= 13'(HOUR_SECS)) begin
      hour4_nxt = h0 + 5'd1;
      rh4_nxt   = 12'(rh0 - 13'(HOUR_SECS));
    end else begin
      hour4_nxt = h0;
      rh4_nxt   = rh0[11:0];
    end
  end

  always_comb begin
    m0     = pm5_r[21:16];
    s_full = rh5_r - 12'(m0) * 12'(MIN_SECS);
    s0     = s_full[6:0];
    tod_nxt.hour = hour5_r;
    if (s0 >= 7'(MIN_SECS)) begin
      tod_nxt.minute = m0 + 6'd1;
      tod_nxt.second = 6'(s0 - 7'(MIN_SECS));
    end else begin
      tod_nxt.minute = m0;
      tod_nxt.second = s0[5:0];
    end
  end

  always_ff @(posedge clk) begin
    ph3_r   <= ph3_nxt;
    rem3_r  <= rem;
    hour4_r <= hour4_nxt;
    rh4_r   <= rh4_nxt;
    hour5_r <= hour4_r;
    pm5_r   <= pm5_nxt;
    rh5_r   <= rh4_r;
    tod_r   <= tod_nxt;
  end

  assign tod = tod_r;

endmodule

### sv/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while busy is low; six register stages, split into day/second
// division, year walk, month lookup and time-of-day division by reciprocals.
// busy is high only during reset and the first cycle after it.
// Reset (rst_n, synchronous) clears the valid pipeline; no results are pending.
// out_valid is high for a single cycle per result; the receiver cannot stall.
module epoch_seconds_to_calendar_top
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic        out_out_of_range
);

  localparam int Depth = 6;

  logic             busy_r;
  logic [Depth-1:0] vld_r, vld_nxt;
  logic [Depth-1:0] oor_r;
  logic             accept;
  logic             good;

  logic [15:0] days;
  logic [16:0] rem;
  date_t       date;
  tod_t        tod;

  assign accept  = start && !busy_r;
  assign vld_nxt = {vld_r[Depth-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oor_r <= {oor_r[Depth-2:0], (in_epoch_seconds >= LIMIT_SECONDS)};
  end

  esc_daysplit u_daysplit (
    .clk  (clk),
    .secs (in_epoch_seconds),
    .days (days),
    .rem  (rem)
  );

  esc_date u_date (
    .clk  (clk),
    .days (days),
    .date (date)
  );

  esc_tod u_tod (
    .clk (clk),
    .rem (rem),
    .tod (tod)
  );

  assign good             = vld_r[Depth-1] && !oor_r[Depth-1];
  assign busy             = busy_r;
  assign out_valid        = vld_r[Depth-1];
  assign out_out_of_range = vld_r[Depth-1] && oor_r[Depth-1];
  assign out_year         = good ? date.year  : '0;
  assign out_month        = good ? date.month : '0;
  assign out_day_of_month = good ? date.day   : '0;
  assign out_hour         = good ? tod.hour   : '0;
  assign out_minute       = good ? tod.minute : '0;
  assign out_second       = good ? tod.second : '0;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("accepted item did not produce a result after six cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result without an accepted item");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |->
      (out_year >= 12'd1970 && out_year <= 12'd2099 &&
       out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month >= 5'd1 &&
       out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59))
    else $error("calendar field out of range");
`endif

endmodule

### verif/epoch_seconds_to_calendar_top_test.sv
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_top_test;
  import esc_pkg::LIMIT_SECONDS;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned LAST_DAY      = 47481;  // 2099-12-31 as a day count
  localparam int          NUM_DIRECTED  = 24;
  localparam int          ITEMS_PER_PHASE = 300;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        out_of_range;
  } cal_result_t;

  typedef struct packed {
    logic [31:0] secs;
    cal_result_t want;
  } pending_date_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    cal_result_t want;
  } directed_row_t;

  localparam cal_result_t NOT_TYPED = '0;
  localparam cal_result_t PAST_2099 = {38'd0, 1'b1};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic        out_out_of_range;

  pending_date_t pending_dates[$];
  directed_row_t directed_rows [NUM_DIRECTED];
  int            idle_pct;
  int            err_count;
  int            cycle_count;

  epoch_seconds_to_calendar_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic cal_result_t calendar_of(input logic [31:0] secs);
    cal_result_t r;
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mo;
    int unsigned len;
    logic        leap;
    r = '0;
    if (secs >= LIMIT_SECONDS) begin
      r.out_of_range = 1'b1;
      return r;
    end
    days = secs / SECS_PER_DAY;
    rem  = secs % SECS_PER_DAY;
    yr   = 1970;
    leap = 1'b0;
    while (days >= (leap ? 366 : 365)) begin
      days = days - (leap ? 366 : 365);
      yr   = yr + 1;
      leap = (yr % 4) == 0;
    end
    mo  = 0;
    len = 31;
    while (mo < 11 && days >= len) begin
      days = days - len;
      mo   = mo + 1;
      if (mo == 1) begin
        len = leap ? 29 : 28;
      end else if (mo == 3 || mo == 5 || mo == 8 || mo == 10) begin
        len = 30;
      end else begin
        len = 31;
      end
    end
    r.year         = yr[11:0];
    r.month        = mo[3:0] + 4'd1;
    r.day_of_month = days[4:0] + 5'd1;
    r.hour         = 5'(rem / SECS_PER_HOUR);
    r.minute       = 6'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
    r.second       = 6'(rem % SECS_PER_MIN);
    return r;
  endfunction

  function automatic logic [31:0] random_secs();
    int unsigned d;
    int unsigned s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom_range(0, LIMIT_SECONDS - 1);
      4, 5:       s = $urandom;
      6, 7, 8: begin
        d = $urandom_range(0, LAST_DAY);
        case ($urandom_range(0, 2))
          0:       s = d * SECS_PER_DAY;
          1:       s = d * SECS_PER_DAY + SECS_PER_DAY - 1;
          default: s = d * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          s = LIMIT_SECONDS - 2 + $urandom_range(0, 3);
        end else begin
          s = $urandom_range(LIMIT_SECONDS, 32'hFFFF_FFFF);
        end
      end
    endcase
    return s;
  endfunction

  task automatic send_item(input logic [31:0] secs, input logic typed, input cal_result_t want);
    pending_date_t p;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_epoch_seconds <= $urandom;
    end
    @(negedge clk);
    start <= 1'b1;
    in_epoch_seconds <= secs;
    while (busy) @(negedge clk);
    p.secs = secs;
    p.want = typed ? want : calendar_of(secs);
    pending_dates.push_back(p);
  endtask

  task automatic drain_dates();
    @(negedge clk);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("epoch_seconds_to_calendar_top_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    cal_result_t   got;
    pending_date_t p;
    if (rst_n && out_valid) begin
      got = {out_year, out_month, out_day_of_month, out_hour, out_minute, out_second,
             out_out_of_range};
      if (pending_dates.size() == 0) begin
        err_count = err_count + 1;
        if (err_count <= 10) begin
          $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d oor=%0b", got.year, got.month,
                   got.day_of_month, got.hour, got.minute, got.second, got.out_of_range);
        end
      end else begin
        p = pending_dates.pop_front();
        if (got !== p.want) begin
          err_count = err_count + 1;
          if (err_count <= 10) begin
            $display("mismatch secs=%0d exp %0d-%0d-%0d %0d:%0d:%0d oor=%0b",
                     p.secs, p.want.year, p.want.month, p.want.day_of_month, p.want.hour,
                     p.want.minute, p.want.second, p.want.out_of_range);
            $display("                  got %0d-%0d-%0d %0d:%0d:%0d oor=%0b",
                     got.year, got.month, got.day_of_month, got.hour, got.minute,
                     got.second, got.out_of_range);
          end
        end
      end
    end
  end

  initial begin
    int i;
    int ph;
    cycle_count      = 0;
    err_count        = 0;
    idle_pct         = 35;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_epoch_seconds = '0;

    directed_rows[0]  = {32'd0,          1'b1, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b0};
    directed_rows[1]  = {32'd4102444799, 1'b1,
                         12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0};
    directed_rows[2]  = {32'd4102444800, 1'b1, PAST_2099};
    directed_rows[3]  = {32'hFFFF_FFFF,  1'b1, PAST_2099};
    directed_rows[4]  = {32'd59,         1'b0, NOT_TYPED};
    directed_rows[5]  = {32'd60,         1'b0, NOT_TYPED};
    directed_rows[6]  = {32'd3599,       1'b0, NOT_TYPED};
    directed_rows[7]  = {32'd3600,       1'b0, NOT_TYPED};
    directed_rows[8]  = {32'd86399,      1'b0, NOT_TYPED};
    directed_rows[9]  = {32'd86400,      1'b0, NOT_TYPED};
    directed_rows[10] = {32'd31535999,   1'b0, NOT_TYPED};  // end of 1970
    directed_rows[11] = {32'd31536000,   1'b0, NOT_TYPED};
    directed_rows[12] = {32'd63071999,   1'b0, NOT_TYPED};  // end of 1971
    directed_rows[13] = {32'd63072000,   1'b0, NOT_TYPED};  // first leap year
    directed_rows[14] = {32'd68169599,   1'b0, NOT_TYPED};
    directed_rows[15] = {32'd68169600,   1'b0, NOT_TYPED};  // 1972-02-29
    directed_rows[16] = {32'd68256000,   1'b0, NOT_TYPED};
    directed_rows[17] = {32'd99792000,   1'b0, NOT_TYPED};  // 1973-03-01
    directed_rows[18] = {32'd951782400,  1'b0, NOT_TYPED};  // 2000-02-29
    directed_rows[19] = {32'd1234567890, 1'b0, NOT_TYPED};
    directed_rows[20] = {32'd2147483647, 1'b0, NOT_TYPED};
    directed_rows[21] = {32'd2147483648, 1'b0, NOT_TYPED};
    directed_rows[22] = {32'd4102358400, 1'b0, NOT_TYPED};
    directed_rows[23] = {32'hAAAA_AAAA,  1'b0, NOT_TYPED};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_item(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_dates();

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 35 : (ph == 1) ? 65 : 0;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(random_secs(), 1'b0, NOT_TYPED);
      end
      drain_dates();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_dates.size() == 0) begin
      $display("epoch_seconds_to_calendar_top_test OK");
    end else begin
      $display("epoch_seconds_to_calendar_top_test NOT OK");
    end
    $finish;
  end

endmodule
